[rtl/gcd_lcm_pkg.sv]
`default_nettype none

package gcd_lcm_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int PC_W = 4;

    typedef logic [PC_W-1:0] pc_t;
    typedef logic [2:0]      op_t;
    typedef logic [2:0]      cond_t;

    // datapath operations
    localparam op_t OP_NOP      = 3'd0;
    localparam op_t OP_LOAD     = 3'd1;   // take operand magnitudes
    localparam op_t OP_EDIV_INI = 3'd2;   // divider setup for x % y
    localparam op_t OP_DIV      = 3'd3;   // one restoring divide step
    localparam op_t OP_EUPD     = 3'd4;   // x <= y, y <= remainder
    localparam op_t OP_QDIV_INI = 3'd5;   // divider setup for |a| / gcd
    localparam op_t OP_MUL_INI  = 3'd6;   // clear accumulator, keep quotient
    localparam op_t OP_MUL      = 3'd7;   // one shift-add multiply step

    // jump conditions
    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_NO_IN    = 3'd2;
    localparam cond_t C_Y_ZERO   = 3'd3;
    localparam cond_t C_X_ZERO   = 3'd4;
    localparam cond_t C_CNT_RUN  = 3'd5;
    localparam cond_t C_OUT_BUSY = 3'd6;
    localparam cond_t C_FINISH   = 3'd7;  // unconditional, also loads result

    // program steps
    localparam pc_t S_IDLE = 4'd0;
    localparam pc_t S_TEST = 4'd1;
    localparam pc_t S_EDIV = 4'd2;
    localparam pc_t S_EUPD = 4'd3;
    localparam pc_t S_QUOT = 4'd4;
    localparam pc_t S_QDIV = 4'd5;
    localparam pc_t S_MINI = 4'd6;
    localparam pc_t S_MUL  = 4'd7;
    localparam pc_t S_WAIT = 4'd8;
    localparam pc_t S_FIN  = 4'd9;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode_rom(input pc_t pc);
        ctrl_word_t cw;
        unique case (pc)
            S_IDLE:  cw = '{OP_LOAD,     C_NO_IN,    S_IDLE};
            S_TEST:  cw = '{OP_EDIV_INI, C_Y_ZERO,   S_QUOT};
            S_EDIV:  cw = '{OP_DIV,      C_CNT_RUN,  S_EDIV};
            S_EUPD:  cw = '{OP_EUPD,     C_ALWAYS,   S_TEST};
            S_QUOT:  cw = '{OP_QDIV_INI, C_X_ZERO,   S_WAIT};
            S_QDIV:  cw = '{OP_DIV,      C_CNT_RUN,  S_QDIV};
            S_MINI:  cw = '{OP_MUL_INI,  C_NEVER,    S_IDLE};
            S_MUL:   cw = '{OP_MUL,      C_CNT_RUN,  S_MUL};
            S_WAIT:  cw = '{OP_NOP,      C_OUT_BUSY, S_WAIT};
            S_FIN:   cw = '{OP_NOP,      C_FINISH,   S_IDLE};
            default: cw = '{OP_NOP,      C_ALWAYS,   S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[rtl/gcd_lcm_unit_top.sv]
// GCD and LCM of two signed DATA_WIDTH-bit integers, both taken on magnitudes.
// A small microcoded sequencer runs Euclid's algorithm on one shared datapath:
// each remainder is a restoring divide (plus a setup and an update step), then
// |a|/gcd takes one more divide and the product with |b| a shift-add multiply,
// each one bit per cycle. The number k of remainder steps is at most about
// 1.44*DATA_WIDTH. Before its result is loaded, a request waits until a stalled
// earlier result has been taken. One request is in work at a time; a finished
// result waits in the output register while the next request is taken. A
// multiple above 2^(DATA_WIDTH-1)-1 gives lcm_value 0 and lcm_overflow 1; a gcd
// of exactly 2^(DATA_WIDTH-1) saturates to all ones.
`default_nettype none

module gcd_lcm_unit_top #(
    parameter int DATA_WIDTH = gcd_lcm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [DATA_WIDTH-1:0] operand_a,
    input  wire logic [DATA_WIDTH-1:0] operand_b,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DATA_WIDTH-2:0]      gcd_value,
    output logic [DATA_WIDTH-2:0]      lcm_value,
    output logic                       lcm_overflow
);
    import gcd_lcm_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    pc_t             pc_reg, pc_next;
    ctrl_word_t      cw;
    logic            jump;

    logic [DW-1:0]   ma_reg, ma_next;
    logic [DW-1:0]   mb_reg, mb_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [DW-1:0]   r_reg, r_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic            out_valid_reg, out_valid_next;
    logic [DW-2:0]   gcd_reg, gcd_next;
    logic [DW-2:0]   lcm_reg, lcm_next;
    logic            ovf_reg, ovf_next;

    logic [DW-1:0]   mag_a, mag_b;
    logic [DW+1:0]   div_trial;
    logic [DW:0]     div_shift;
    logic [DW:0]     mul_sum;
    logic            prod_big;

    assign mag_a = operand_a[DW-1] ? (~operand_a + DW'(1)) : operand_a;
    assign mag_b = operand_b[DW-1] ? (~operand_b + DW'(1)) : operand_b;

    // restoring divide: shift remainder left, try to subtract divisor
    assign div_shift = {r_reg, q_reg[DW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, d_reg};

    // shift-add multiply: accumulator in r, multiplier shifts out of q
    assign mul_sum = q_reg[0] ? ({1'b0, r_reg} + {1'b0, mb_reg}) : {1'b0, r_reg};

    // product {r, q} must fit in DW-1 bits
    assign prod_big = (r_reg != '0) || q_reg[DW-1];

    assign cw = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !in_valid;
            C_Y_ZERO:   jump = (y_reg == '0);
            C_X_ZERO:   jump = (x_reg == '0);
            C_CNT_RUN:  jump = (cnt_reg != CNT_LAST);
            C_OUT_BUSY: jump = out_valid_reg && out_stall;
            C_FINISH:   jump = 1'b1;
            default:    jump = 1'b1;
        endcase
    end

    assign pc_next = jump ? cw.target : pc_t'(pc_reg + pc_t'(1));

    always_comb
    begin
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        d_next   = d_reg;
        r_next   = r_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        unique case (cw.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                ma_next = mag_a;
                mb_next = mag_b;
                x_next  = mag_a;
                y_next  = mag_b;
            end
            OP_EDIV_INI:
            begin
                q_next   = x_reg;
                r_next   = '0;
                d_next   = y_reg;
                cnt_next = '0;
            end
            OP_DIV:
            begin
                if (!div_trial[DW+1])
                begin
                    r_next = div_trial[DW-1:0];
                end
                else
                begin
                    r_next = div_shift[DW-1:0];
                end
                q_next   = {q_reg[DW-2:0], !div_trial[DW+1]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_EUPD:
            begin
                x_next = y_reg;
                y_next = r_reg;
            end
            OP_QDIV_INI:
            begin
                q_next   = ma_reg;
                r_next   = '0;
                d_next   = x_reg;
                cnt_next = '0;
            end
            OP_MUL_INI:
            begin
                r_next   = '0;
                cnt_next = '0;
            end
            OP_MUL:
            begin
                r_next   = mul_sum[DW:1];
                q_next   = {mul_sum[0], q_reg[DW-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // result register; when the gcd is zero both operands were zero and q holds zero
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        gcd_next       = gcd_reg;
        lcm_next       = lcm_reg;
        ovf_next       = ovf_reg;
        if (cw.cond == C_FINISH)
        begin
            out_valid_next = 1'b1;
            gcd_next       = x_reg[DW-1] ? '1 : x_reg[DW-2:0];
            ovf_next       = prod_big;
            lcm_next       = prod_big ? '0 : q_reg[DW-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        gcd_reg <= gcd_next;
        lcm_reg <= lcm_next;
        ovf_reg <= ovf_next;
    end

    assign in_stall     = (pc_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign gcd_value    = gcd_reg;
    assign lcm_value    = lcm_reg;
    assign lcm_overflow = ovf_reg;

endmodule

`default_nettype wire

[rtl/gcd_lcm_chk.sv]
`default_nettype none

module gcd_lcm_chk #(
    parameter int DATA_WIDTH = gcd_lcm_pkg::DATA_WIDTH_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic [DATA_WIDTH-1:0] operand_a,
    input wire logic [DATA_WIDTH-1:0] operand_b,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [DATA_WIDTH-2:0] gcd_value,
    input wire logic [DATA_WIDTH-2:0] lcm_value,
    input wire logic                  lcm_overflow
);

    // a request is still in work in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gcd_value)
            && $stable(lcm_value) && $stable(lcm_overflow))
        else $error("stalled result changed");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lcm_overflow |-> lcm_value == '0)
        else $error("overflowed multiple not zero");

    // a nonzero or overflowed multiple needs both operands nonzero
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lcm_overflow || lcm_value != '0) |-> gcd_value != '0)
        else $error("multiple without divisor");

    a_in_protocol: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(operand_a) && $stable(operand_b))
        else $error("stalled request changed");

endmodule

bind gcd_lcm_unit_top gcd_lcm_chk #(.DATA_WIDTH(DATA_WIDTH)) u_gcd_lcm_chk (.*);

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = gcd_lcm_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int DRAIN_CYCLES = 2000;       // covers a worst-case Euclid run
    localparam int TIMEOUT_CYCLES = 12_000_000;
    localparam longint MAG_MAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [DW-2:0] gcd;
        logic [DW-2:0] lcm;
        logic          ovf;
    } gcd_lcm_t;

    class gcd_lcm_scoreboard;
        gcd_lcm_t expected_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // magnitude of a two's complement word, 2^(DW-1) kept in full
        function logic [63:0] abs_of(logic [DW-1:0] v);
            logic [DW-1:0] neg;
            neg = ~v + 1'b1;
            return v[DW-1] ? 64'(neg) : 64'(v);
        endfunction

        function gcd_lcm_t gcd_lcm_of(logic [DW-1:0] a, logic [DW-1:0] b);
            logic [63:0] ma, mb, x, y, t, q, lcm, pmax;
            logic        ovf;
            gcd_lcm_t    r;
            pmax = 64'(MAG_MAX);
            ma = abs_of(a);
            mb = abs_of(b);
            x = (mb > ma) ? mb : ma;
            y = (mb > ma) ? ma : mb;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            lcm = 0;
            ovf = 1'b0;
            if (x != 0)
            begin
                q = ma / x;
                if (q != 0 && mb > pmax / q)
                    ovf = 1'b1;
                else
                    lcm = q * mb;
            end
            if (x > pmax)
                x = pmax;
            r.gcd = x[DW-2:0];
            r.lcm = lcm[DW-2:0];
            r.ovf = ovf;
            return r;
        endfunction

        function void note_request(logic [DW-1:0] a, logic [DW-1:0] b);
            expected_q.push_back(gcd_lcm_of(a, b));
        endfunction

        function void check_result(logic [DW-2:0] g, logic [DW-2:0] l, logic o);
            gcd_lcm_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: gcd_value %0d lcm_value %0d lcm_overflow %0d",
                       g, l, o);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (g !== e.gcd)
            begin
                $error("gcd_value: expected %0d, got %0d", e.gcd, g);
                errors++;
            end
            if (l !== e.lcm)
            begin
                $error("lcm_value: expected %0d, got %0d", e.lcm, l);
                errors++;
            end
            if (o !== e.ovf)
            begin
                $error("lcm_overflow: expected %0d, got %0d", e.ovf, o);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [DW-1:0] operand_a = '0;
    logic [DW-1:0] operand_b = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [DW-2:0] gcd_value;
    logic [DW-2:0] lcm_value;
    logic          lcm_overflow;

    gcd_lcm_scoreboard sb = new();
    int cycle_count = 0;
    int stall_mode = 0;
    int mode_left = 0;

    gcd_lcm_unit_top #(.DATA_WIDTH(DW)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gcd_value    (gcd_value),
        .lcm_value    (lcm_value),
        .lcm_overflow (lcm_overflow)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // both channels sampled on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(operand_a, operand_b);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(gcd_value, lcm_value, lcm_overflow);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: stall behavior switches at random between four modes
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 600);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ((mode_left % 8) < 5);
            default: out_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    function automatic logic [DW-1:0] with_random_sign(longint m);
        if ($urandom_range(0, 1))
            return DW'(-m);
        return DW'(m);
    endfunction

    function automatic longint fib(int n);
        longint f0, f1, t;
        f0 = 0;
        f1 = 1;
        for (int i = 0; i < n; i++)
        begin
            t = f0 + f1;
            f0 = f1;
            f1 = t;
        end
        return f0;
    endfunction

    task automatic send_request(input logic [DW-1:0] a, input logic [DW-1:0] b);
        in_valid <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        // the request taken at this edge reaches the scoreboard first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic make_pair(output logic [DW-1:0] a, output logic [DW-1:0] b);
        longint g, x, y;
        int     n;
        case ($urandom_range(0, 9))
            0:
            begin
                a = DW'({$urandom(), $urandom()});
                b = DW'({$urandom(), $urandom()});
            end
            1:
            begin
                a = with_random_sign($urandom_range(0, 300));
                b = with_random_sign($urandom_range(0, 300));
            end
            2, 3, 4:
            begin
                // shared factor, small cofactors: lcm usually fits
                g = $urandom_range(1, 2 ** $urandom_range(1, 16) - 1);
                x = $urandom_range(0, 2 ** $urandom_range(0, 15));
                y = $urandom_range(0, 2 ** $urandom_range(0, 15));
                a = with_random_sign(g * x);
                b = with_random_sign(g * y);
            end
            5:
            begin
                // operand product close to the top of the signed range
                x = $urandom_range(1, 65535);
                y = MAG_MAX / x - $urandom_range(0, 2);
                a = with_random_sign(x);
                b = with_random_sign(y);
            end
            6:
            begin
                a = ($urandom_range(0, 15) == 0) ? MOST_NEG
                                                  : with_random_sign(64'd1 << $urandom_range(0, 30));
                b = with_random_sign(64'd1 << $urandom_range(0, 30));
            end
            7:
            begin
                x = $urandom_range(0, 2 ** $urandom_range(0, 31) - 1);
                if ($urandom_range(0, 1))
                begin
                    a = '0;
                    b = with_random_sign(x);
                end
                else
                begin
                    a = with_random_sign(x);
                    b = '0;
                end
            end
            8:
            begin
                // consecutive Fibonacci numbers: longest remainder chains
                n = $urandom_range(2, 46);
                a = with_random_sign(fib(n));
                b = with_random_sign(fib(n - 1));
            end
            default:
            begin
                x = $urandom_range(1, 2 ** 30);
                y = ($urandom_range(0, 1)) ? x : 2 * x;
                a = with_random_sign(x);
                b = with_random_sign(y);
            end
        endcase
    endtask

    initial
    begin
        logic [DW-1:0] a, b;
        int            sent, burst;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request('0, '0);
        send_request('0, DW'(-5));
        send_request(DW'(7), '0);
        send_request(MOST_NEG, '0);
        send_request('0, MOST_NEG);
        send_request(MOST_NEG, MOST_NEG);
        send_request(MOST_NEG, DW'(1));
        send_request(MOST_NEG, DW'(-1));
        send_request(MOST_NEG, DW'(MAG_MAX));
        send_request(MOST_NEG, DW'(64'd1 << 30));
        send_request(DW'(MAG_MAX), DW'(MAG_MAX));
        send_request(DW'(MAG_MAX), DW'(1));
        send_request(DW'(MAG_MAX), DW'(MAG_MAX - 1));
        send_request(DW'(-MAG_MAX), DW'(-1));
        send_request(DW'(-12), DW'(18));
        send_request(DW'(12), DW'(-18));
        send_request(DW'(-12), DW'(-18));
        send_request(DW'(1), DW'(1));
        send_request(DW'(65537), DW'(32771));
        send_request(DW'(46341), DW'(46340));
        send_request(DW'(64'd1 << 30), DW'(2));
        send_request(DW'(-(64'sd1 <<< 30)), DW'(64'd3 << 28));
        send_request(DW'(fib(46)), DW'(fib(45)));
        send_request(DW'(-fib(45)), DW'(fib(44)));

        // hold off until the directed requests have all come back
        wait_for_results();
        idle_for(5);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++)
            begin
                make_pair(a, b);
                send_request(a, b);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                wait_for_results();
            else if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 40));
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $error("results missing: %0d requests never answered", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
